### design/rbrle_pkg.sv
// ----------------------------------------------------------------------------
// rbrle_pkg
// Shared types, constants and helpers of the row-bounded run-length encoder.
// ----------------------------------------------------------------------------
package rbrle_pkg;

	// Fixed field widths.
	localparam int unsigned TILE_W   = 8;
	localparam int unsigned LEN_W    = 8;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned RWIDTH_W = 11;

	// Defaults of the top-level parameters.
	localparam int unsigned MAX_ROW_WIDTH_DEF = 1024;
	localparam int unsigned JOB_DEPTH_DEF     = 4;

	// Longest run that one pair may carry.
	localparam logic [LEN_W-1:0] MAX_RUN = LEN_W'(255);

	// Row offset arithmetic.
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(65535);
	localparam logic [OFFSET_W-1:0] PAIR_BYTES = OFFSET_W'(2);

	// Row width after reset.
	localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST = RWIDTH_W'(20);

	// Result kinds.
	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_ROW  = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [TILE_W-1:0]   run_value;
		logic [LEN_W-1:0]    run_length;
		logic [OFFSET_W-1:0] row_offset;
		logic                item_done;
		logic                stream_done;
	} result_t;

	// All results caused by one item: an optional leading result (row entry
	// or a run closed by a change of tile or at the run cap) and an optional closing pair.
	typedef struct packed {
		logic    a_valid;
		result_t a;
		logic    b_valid;
		result_t b;
	} job_t;

	// Front-to-queue push request.
	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	function automatic result_t make_pair(input logic [TILE_W-1:0] value,
		input logic [LEN_W-1:0] length, input logic last, input logic done);
		result_t r;
		r.kind        = KIND_PAIR;
		r.run_value   = value;
		r.run_length  = length;
		r.row_offset  = '0;
		r.item_done   = done;
		r.stream_done = last;
		return r;
	endfunction

	function automatic result_t make_row(input logic [OFFSET_W-1:0] offset,
		input logic done);
		result_t r;
		r.kind        = KIND_ROW;
		r.run_value   = '0;
		r.run_length  = '0;
		r.row_offset  = offset;
		r.item_done   = done;
		r.stream_done = 1'b0;
		return r;
	endfunction

	function automatic logic [OFFSET_W-1:0] add_pair(input logic [OFFSET_W-1:0] b);
		logic [OFFSET_W-1:0] r;
		if (b > OFFSET_MAX - PAIR_BYTES) begin
			r = OFFSET_MAX;
		end else begin
			r = b + PAIR_BYTES;
		end
		return r;
	endfunction

endpackage

### design/rbrle_channels.sv
// ----------------------------------------------------------------------------
// rbrle channels
// Valid/ready channel interfaces for tiles, results and the row width write.
// ----------------------------------------------------------------------------
interface rbrle_tile_if;
	logic                        valid;
	logic                        ready;
	logic [rbrle_pkg::TILE_W-1:0] tile;
	logic                        map_end;

	modport source (output valid, output tile, output map_end, input ready);
	modport sink   (input valid, input tile, input map_end, output ready);
endinterface

interface rbrle_result_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [rbrle_pkg::TILE_W-1:0]    run_value;
	logic [rbrle_pkg::LEN_W-1:0]     run_length;
	logic [rbrle_pkg::OFFSET_W-1:0]  row_offset;
	logic                            item_done;
	logic                            stream_done;

	modport source (output valid, output kind, output run_value, output run_length,
		output row_offset, output item_done, output stream_done, input ready);
	modport sink   (input valid, input kind, input run_value, input run_length,
		input row_offset, input item_done, input stream_done, output ready);
endinterface

interface rbrle_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rbrle_pkg::RWIDTH_W-1:0] row_width;

	modport source (output valid, output row_width, input ready);
	modport sink   (input valid, input row_width, output ready);
endinterface

### design/rbrle_front.sv
// ----------------------------------------------------------------------------
// rbrle_front
// Accepts tiles, tracks the open run, column and offset, and forms the job.
// ----------------------------------------------------------------------------
module rbrle_front #(
	parameter int unsigned MAX_ROW_WIDTH = rbrle_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rbrle_pkg::TILE_W-1:0]     tile,
	input  logic                             map_end,
	input  logic [rbrle_pkg::RWIDTH_W-1:0]   row_width,
	input  logic                             queue_full,
	output rbrle_pkg::push_t                 push_o
);

	localparam int unsigned CW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int unsigned WW = (CW > rbrle_pkg::RWIDTH_W) ? CW : rbrle_pkg::RWIDTH_W;

	logic [rbrle_pkg::TILE_W-1:0]   value_q;
	logic [rbrle_pkg::LEN_W-1:0]    length_q;
	logic [CW-1:0]                  column_q;
	logic [rbrle_pkg::OFFSET_W-1:0] bytes_q;

	logic [WW-1:0]                  rw_x;
	logic [WW-1:0]                  max_x;
	logic [WW-1:0]                  w_eff;
	logic [CW:0]                    col_inc;
	logic                           col_end;
	logic                           mid_close;
	logic                           open_new;
	logic [rbrle_pkg::TILE_W-1:0]   nvalue;
	logic [rbrle_pkg::LEN_W-1:0]    nlength;
	logic [rbrle_pkg::OFFSET_W-1:0] bytes_a;
	logic                           row_start;
	logic                           accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		rw_x  = WW'(row_width);
		max_x = WW'(MAX_ROW_WIDTH);
		if (rw_x == '0) begin
			w_eff = WW'(1);
		end else if (rw_x > max_x) begin
			w_eff = max_x;
		end else begin
			w_eff = rw_x;
		end
	end

	assign col_inc   = {1'b0, column_q} + (CW+1)'(1);
	assign col_end   = (WW+1)'(col_inc) >= {1'b0, w_eff};
	assign row_start = (column_q == '0);
	assign mid_close = (length_q != '0) &&
		((tile != value_q) || (length_q >= rbrle_pkg::MAX_RUN));
	assign open_new  = (length_q == '0) || mid_close;
	assign nvalue    = open_new ? tile : value_q;
	assign nlength   = open_new ? rbrle_pkg::LEN_W'(1) : length_q + rbrle_pkg::LEN_W'(1);
	assign bytes_a   = mid_close ? rbrle_pkg::add_pair(bytes_q) : bytes_q;

	always_comb begin
		push_o.job.a_valid = row_start || mid_close;
		push_o.job.b_valid = map_end || col_end;
		if (row_start) begin
			push_o.job.a = rbrle_pkg::make_row(bytes_q, !push_o.job.b_valid);
		end else begin
			push_o.job.a = rbrle_pkg::make_pair(value_q, length_q, 1'b0,
				!push_o.job.b_valid);
		end
		push_o.job.b = rbrle_pkg::make_pair(nvalue, nlength, map_end, 1'b1);
		push_o.push  = accept && (push_o.job.a_valid || push_o.job.b_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= '0;
			length_q <= '0;
			column_q <= '0;
			bytes_q  <= '0;
		end else if (accept) begin
			if (map_end) begin
				value_q  <= '0;
				length_q <= '0;
				column_q <= '0;
				bytes_q  <= '0;
			end else if (col_end) begin
				value_q  <= nvalue;
				length_q <= '0;
				column_q <= '0;
				bytes_q  <= rbrle_pkg::add_pair(bytes_a);
			end else begin
				value_q  <= nvalue;
				length_q <= nlength;
				column_q <= col_inc[CW-1:0];
				bytes_q  <= bytes_a;
			end
		end
	end

endmodule

### design/rbrle_job_queue.sv
// ----------------------------------------------------------------------------
// rbrle_job_queue
// Small first-in first-out store of jobs between the front and the back.
// ----------------------------------------------------------------------------
module rbrle_job_queue #(
	parameter int unsigned DEPTH = rbrle_pkg::JOB_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rbrle_pkg::push_t  push_i,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output rbrle_pkg::job_t   head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	rbrle_pkg::job_t jobs_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = jobs_q[rd_ptr_q];
	assign do_push = push_i.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			jobs_q[wr_ptr_q] <= push_i.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

### design/rbrle_back.sv
// ----------------------------------------------------------------------------
// rbrle_back
// Unpacks queued jobs into single results and holds them in an output register.
// ----------------------------------------------------------------------------
module rbrle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  rbrle_pkg::job_t       head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rbrle_pkg::result_t    out_res
);

	logic               phase_q;
	logic               valid_q;
	rbrle_pkg::result_t res_q;
	logic               load;
	logic               emit;
	logic               sel_b;

	assign load  = !valid_q || out_ready;
	assign emit  = load && !empty;
	// The second slot goes out once the first is done or when there is no first.
	assign sel_b = phase_q || !head.a_valid;
	assign pop   = emit && (sel_b || !head.b_valid);

	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= sel_b ? head.b : head.a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				phase_q <= !pop;
			end else if (load) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/row_bounded_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// row_bounded_run_length_encoder_unit
// Run-length encodes a tile map into (tile, count) pairs with row-start
// offset entries, closing every run at each row end and at the map end.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                                          Item
// tiles    in   tile[7:0], map_end                                               one tile
// results  out  kind, run_value, run_length, row_offset, item_done, stream_done  one result
// cfg      in   row_width[10:0]                                                  one write
//
// Tiles are taken whenever the job queue has room, back to back if offered.
// A tile's first result passes through the queue, then the output register; the
// result port moves one result per cycle while the receiver is ready, and a tile
// that causes two results sends them out one after the other.
// Reset clears run, column, offset, queue and output valid and loads row width 20.
// A result-side stall fills the job queue and only then stops tiles.
//
module row_bounded_run_length_encoder_unit #(
	parameter int unsigned MAX_ROW_WIDTH = rbrle_pkg::MAX_ROW_WIDTH_DEF,
	parameter int unsigned JOB_DEPTH     = rbrle_pkg::JOB_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rbrle_tile_if.sink             tiles,
	rbrle_result_if.source         results,
	rbrle_cfg_if.sink              cfg
);

	// The row width register. Writes are taken at any time; the user only
	// writes it while the block is idle.
	logic [rbrle_pkg::RWIDTH_W-1:0] row_width_q;

	rbrle_pkg::push_t   push;
	rbrle_pkg::job_t    head;
	rbrle_pkg::result_t res;
	logic               full;
	logic               empty;
	logic               pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= rbrle_pkg::ROW_WIDTH_RST;
		end else if (cfg.valid) begin
			row_width_q <= cfg.row_width;
		end
	end

	// The front owns the run state and turns each tile that causes a result into
	// one job that lists every result the tile causes.
	rbrle_front #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (tiles.valid),
		.in_ready   (tiles.ready),
		.tile       (tiles.tile),
		.map_end    (tiles.map_end),
		.row_width  (row_width_q),
		.queue_full (full),
		.push_o     (push)
	);

	// The queue decouples the front from output stalls.
	rbrle_job_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (push),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// The back sends the job's results out one per cycle while results.ready is high.
	rbrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_res   (res)
	);

	assign results.kind        = res.kind;
	assign results.run_value   = res.run_value;
	assign results.run_length  = res.run_length;
	assign results.row_offset  = res.row_offset;
	assign results.item_done   = res.item_done;
	assign results.stream_done = res.stream_done;

	// A pair never carries an empty run.
	a_pair_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == rbrle_pkg::KIND_PAIR) |->
			(results.run_length != '0))
		else $error("pair with zero run length");

	// A row-start entry carries no run and never ends the map.
	a_row_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == rbrle_pkg::KIND_ROW) |->
			(results.run_length == '0 && results.stream_done == 1'b0))
		else $error("row-start entry carries run fields");

	// The final pair of a map is always the last result of its tile.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.stream_done) |-> results.item_done)
		else $error("map end not on the last result of its tile");

	// Tiles are refused only while the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tiles.ready |-> full)
		else $error("tiles refused with room in the queue");

endmodule

### test/rbrle_run_checker.sv
// ----------------------------------------------------------------------------
// rbrle_run_checker
// Watches the tile, result and row width channels of the encoder, predicts
// every result from the accepted tiles and compares them in order.
// ----------------------------------------------------------------------------
module rbrle_run_checker #(
	parameter int unsigned MAX_ROW_WIDTH = rbrle_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rbrle_tile_if    tiles,
	rbrle_result_if  results,
	rbrle_cfg_if     cfg,
	output int       fail_count,
	output int       results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PRINT_CAP = 40;

	// Predicted encoder state.
	logic [rbrle_pkg::RWIDTH_W-1:0] width_reg;
	logic [rbrle_pkg::TILE_W-1:0]   run_tile;
	logic [rbrle_pkg::LEN_W-1:0]    run_len;
	logic [rbrle_pkg::RWIDTH_W-1:0] col;
	logic [rbrle_pkg::OFFSET_W-1:0] byte_pos;

	rbrle_pkg::result_t owed_results[$];

	function automatic string show(input rbrle_pkg::result_t r);
		return $sformatf(
			"kind=%0d value=%0d length=%0d offset=%0d item_done=%0d stream_done=%0d",
			r.kind, r.run_value, r.run_length, r.row_offset, r.item_done, r.stream_done);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_CAP) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
	endtask

	// Closes the open run as a pair and advances the saturating byte offset.
	function automatic rbrle_pkg::result_t close_run(input logic sdone);
		rbrle_pkg::result_t r;
		r.kind        = rbrle_pkg::KIND_PAIR;
		r.run_value   = run_tile;
		r.run_length  = run_len;
		r.row_offset  = '0;
		r.item_done   = 1'b0;
		r.stream_done = sdone;
		if (byte_pos > rbrle_pkg::OFFSET_MAX - rbrle_pkg::PAIR_BYTES) begin
			byte_pos = rbrle_pkg::OFFSET_MAX;
		end else begin
			byte_pos = byte_pos + rbrle_pkg::PAIR_BYTES;
		end
		return r;
	endfunction

	// Appends the results that one tile causes to the queue of owed results.
	function automatic void encode_tile(input logic [rbrle_pkg::TILE_W-1:0] t,
		input logic last);
		rbrle_pkg::result_t             step_out[3];
		rbrle_pkg::result_t             r;
		int                             n;
		logic [rbrle_pkg::RWIDTH_W-1:0] w;
		n = 0;
		w = width_reg;
		if (w == '0) begin
			w = rbrle_pkg::RWIDTH_W'(1);
		end
		if (w > MAX_ROW_WIDTH) begin
			w = rbrle_pkg::RWIDTH_W'(MAX_ROW_WIDTH);
		end
		if (col == '0) begin
			r.kind        = rbrle_pkg::KIND_ROW;
			r.run_value   = '0;
			r.run_length  = '0;
			r.row_offset  = byte_pos;
			r.item_done   = 1'b0;
			r.stream_done = 1'b0;
			step_out[n]   = r;
			n++;
		end
		if (run_len != '0 && (t != run_tile || run_len >= rbrle_pkg::MAX_RUN)) begin
			step_out[n] = close_run(1'b0);
			n++;
			run_len = '0;
		end
		if (run_len == '0) begin
			run_tile = t;
			run_len  = rbrle_pkg::LEN_W'(1);
		end else begin
			run_len = run_len + rbrle_pkg::LEN_W'(1);
		end
		col = col + rbrle_pkg::RWIDTH_W'(1);
		if (last) begin
			step_out[n] = close_run(1'b1);
			n++;
			run_len  = '0;
			run_tile = '0;
			col      = '0;
			byte_pos = '0;
		end else if (col >= w) begin
			step_out[n] = close_run(1'b0);
			n++;
			run_len = '0;
			col     = '0;
		end
		if (n > 0) begin
			step_out[n-1].item_done = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			owed_results.push_back(step_out[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rbrle_pkg::result_t seen;
		rbrle_pkg::result_t want;
		if (!arst_n) begin
			width_reg  = rbrle_pkg::ROW_WIDTH_RST;
			run_tile   = '0;
			run_len    = '0;
			col        = '0;
			byte_pos   = '0;
			fail_count = 0;
			owed_results.delete();
		end else begin
			// Results first: a result at this edge never belongs to a tile
			// accepted at the same edge.
			if (results.valid && results.ready) begin
				seen.kind        = results.kind;
				seen.run_value   = results.run_value;
				seen.run_length  = results.run_length;
				seen.row_offset  = results.row_offset;
				seen.item_done   = results.item_done;
				seen.stream_done = results.stream_done;
				if (owed_results.size() == 0) begin
					report_mismatch({"unexpected result ", show(seen)});
				end else begin
					want = owed_results.pop_front();
					if (seen !== want) begin
						report_mismatch({"got ", show(seen), " wanted ", show(want)});
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				width_reg = cfg.row_width;
			end
			if (tiles.valid && tiles.ready) begin
				encode_tile(tiles.tile, tiles.map_end);
			end
		end
		results_owed = owed_results.size();
	end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives tile maps and row width writes into the row-bounded run-length
// encoder, with random idling on both sides, and reports the verdict of the
// checker that watches the channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_PCT      = 26;
	// Results pass through the job queue, then the output register; the settle time
	// lets a tile that causes no result work its way through.
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned STALL_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASES        = 10;

	// Row width and item count of each random phase. Zero and the values
	// above the maximum row width check the clamping; the last width is
	// replaced by a random one.
	localparam logic [rbrle_pkg::RWIDTH_W-1:0] PHASE_WIDTH [PHASES] =
		'{11'd1, 11'd0, 11'd2047, 11'd3, 11'd20, 11'd7, 11'd1024, 11'd1025, 11'd300, 11'd13};
	localparam int PHASE_LEN [PHASES] =
		'{80, 60, 260, 100, 120, 100, 260, 100, 180, 60};

	logic clk;
	logic arst_n;

	rbrle_tile_if   tile_ch ();
	rbrle_result_if res_ch ();
	rbrle_cfg_if    cfg_ch ();

	int fail_count;
	int results_owed;
	int cycle_count;
	int stall_left;
	bit calm;

	row_bounded_run_length_encoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tiles   (tile_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	rbrle_run_checker run_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.tiles        (tile_ch),
		.results      (res_ch),
		.cfg          (cfg_ch),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = ~clk;
		end
	end

	// Watchdog: a correct run ends far below the limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side. The ready line drops at random unless the run is in a calm
	// stretch, and stays low for the whole of a requested hold-off, which this
	// process counts down itself.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one tile after a random number of idle cycles and returns at the
	// edge where it was taken. Valid stays high into the next item when no gap
	// is drawn, so it is never lowered and raised in the same step.
	task automatic send_tile(input logic [rbrle_pkg::TILE_W-1:0] t, input logic last);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				tile_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		tile_ch.valid   <= 1'b1;
		tile_ch.tile    <= t;
		tile_ch.map_end <= last;
		@(posedge clk);
		while (!tile_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Stops offering tiles and waits until every owed result has come, then
	// lets the block settle in case the last tile caused no result at all.
	task automatic drain_results();
		tile_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The row width is only ever changed while the block is idle.
	task automatic write_width(input logic [rbrle_pkg::RWIDTH_W-1:0] w);
		drain_results();
		cfg_ch.valid     <= 1'b1;
		cfg_ch.row_width <= w;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Random maps built mostly from runs: short runs of a few tiles, long
	// runs that cross the run length cap, and single noise tiles. Drawing
	// tiles from a tiny set half the time makes neighboring runs merge.
	// A map ends on about one tile in sixty.
	task automatic send_random_tiles(input int count);
		int                           left;
		int                           len;
		int                           pick;
		logic [rbrle_pkg::TILE_W-1:0] t;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				len = $urandom_range(200, 520);
			end else if (pick < 75) begin
				len = $urandom_range(1, 6);
			end else begin
				len = 1;
			end
			if ($urandom_range(0, 1) == 0) begin
				t = rbrle_pkg::TILE_W'($urandom_range(0, 3));
			end else begin
				t = rbrle_pkg::TILE_W'($urandom);
			end
			if (len > left) begin
				len = left;
			end
			for (int k = 0; k < len; k++) begin
				send_tile(t, $urandom_range(0, 59) == 0);
				left--;
			end
		end
	endtask

	initial begin
		logic [rbrle_pkg::RWIDTH_W-1:0] w;
		arst_n           <= 1'b0;
		tile_ch.valid    <= 1'b0;
		tile_ch.tile     <= '0;
		tile_ch.map_end  <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.row_width <= '0;
		stall_left = 0;
		calm       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset width of 20: a map of a single tile,
		// the tile extremes, a repeated tile and a map that ends on a run.
		send_tile(8'h00, 1'b1);
		send_tile(8'hFF, 1'b0);
		send_tile(8'hFF, 1'b0);
		send_tile(8'hFF, 1'b0);
		send_tile(8'h00, 1'b0);
		send_tile(8'hA5, 1'b0);
		send_tile(8'h5A, 1'b0);
		send_tile(8'h5A, 1'b1);

		// One tile per row: every tile opens a row and closes its run.
		write_width(11'd1);
		send_tile(8'h80, 1'b0);
		send_tile(8'h80, 1'b0);
		send_tile(8'h7F, 1'b1);

		// A width of zero behaves as a width of one.
		write_width(11'd0);
		send_tile(8'h01, 1'b0);
		send_tile(8'h01, 1'b1);

		// A full row of three, then two tiles of the next row before the
		// width drops to one: the row must end at the very next tile.
		write_width(11'd3);
		send_tile(8'h09, 1'b0);
		send_tile(8'h09, 1'b0);
		send_tile(8'h09, 1'b0);
		send_tile(8'h04, 1'b0);
		send_tile(8'h04, 1'b0);
		write_width(11'd1);
		send_tile(8'h04, 1'b0);
		send_tile(8'h06, 1'b0);

		// The largest register value acts as the maximum row width.
		write_width(11'd2047);
		send_tile(8'hFF, 1'b0);
		send_tile(8'hFF, 1'b1);

		// Random phases, each at its own row width. Phase four runs with no
		// idling at all, phase three pauses midway until the block is empty,
		// and phase six starts with a long hold-off on the result side while
		// tiles keep coming, so the job queue fills and stalls the input.
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				w = rbrle_pkg::RWIDTH_W'($urandom_range(1, 64));
			end else begin
				w = PHASE_WIDTH[p];
			end
			write_width(w);
			calm = (p == 4);
			if (p == 6) begin
				stall_left = STALL_CYCLES;
			end
			if (p == 3) begin
				send_random_tiles(PHASE_LEN[p] / 2);
				drain_results();
				send_random_tiles(PHASE_LEN[p] - PHASE_LEN[p] / 2);
			end else begin
				send_random_tiles(PHASE_LEN[p]);
			end
		end

		// A closing single-tile map.
		send_tile(8'h3C, 1'b1);
		calm = 1'b0;

		drain_results();
		if (fail_count == 0 && results_owed == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
